>>> sv/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion converter.
package rmq_pkg;

   localparam int FIELD_W       = 16;
   localparam int IN_FIELDS     = 9;
   localparam int OUT_FIELDS    = 4;
   localparam int IN_DATA_W     = IN_FIELDS * FIELD_W;
   localparam int OUT_DATA_W    = OUT_FIELDS * FIELD_W;
   localparam int FRAC_BITS_DEF = 14;
   localparam int LANES         = 3;

   localparam logic [FIELD_W-1:0] SAT_MAX = 16'h7fff;
   localparam logic [FIELD_W-1:0] SAT_MIN = 16'h8000;

   // which component is formed from the root
   typedef enum logic [1:0] {
      BR_W = 2'd0,
      BR_X = 2'd1,
      BR_Y = 2'd2,
      BR_Z = 2'd3
   } branch_type;

endpackage

>>> sv/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion converter, trace method, fixed point.
// Front reg, root chain (QW bits), setup reg, divider (DW = FRAC_BITS + 18), result reg.
// Throughput: one beat per cycle; the square root chain and the divider chain advance
// one cell per cycle, with a single global stall from the result register.
// Reset clears all valid bits; payload registers are not reset.
module rotation_matrix_to_quaternion #(
   parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // u_x, u_y, u_z, v_x, v_y, v_z, w_x, w_y, w_z (16 bits each, lowest first)
   input  logic [rmq_pkg::IN_DATA_W-1:0]  req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // q_x, q_y, q_z, q_w (16 bits each, lowest first)
   output logic [rmq_pkg::OUT_DATA_W-1:0] rsp_tdata
);
   import rmq_pkg::*;

   localparam int RAD_W     = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
   localparam int ACC_W     = RAD_W + 1;
   localparam int QW        = (RAD_W + FRAC_BITS + 1) / 2;
   localparam int VW        = 2 * QW;
   localparam int SW        = QW + 1;
   localparam int DW        = FRAC_BITS + 18;
   localparam int NUM_W     = FIELD_W + 1;
   localparam int SQ_SIDE_W = 2 + LANES * NUM_W;
   localparam int DV_SIDE_W = 2 + LANES + 1 + QW;
   localparam int QT_W      = (QW > FIELD_W) ? QW : FIELD_W;

   logic en;

   // ---------------- front stage ----------------
   logic signed [FIELD_W-1:0] fld [0:IN_FIELDS-1];
   logic signed [ACC_W-1:0]   ux_e, vy_e, wz_e, one_c, tr, rad_s;
   logic signed [NUM_W-1:0]   n_c [0:2];
   logic [RAD_W-1:0]          rad_c, rad_ff;
   branch_type                br_c;
   logic [SQ_SIDE_W-1:0]      fside_ff, fside_in;
   logic                      front_valid_ff;

   always_comb begin
      for (int k = 0; k < IN_FIELDS; k++) begin
         fld[k] = req_tdata[k*FIELD_W +: FIELD_W];
      end
      ux_e  = ACC_W'(fld[0]);
      vy_e  = ACC_W'(fld[4]);
      wz_e  = ACC_W'(fld[8]);
      one_c = ACC_W'(1) << FRAC_BITS;
      tr    = ux_e + vy_e + wz_e;
      if (tr > 0) begin
         br_c   = BR_W;
         rad_s  = tr + one_c;
         n_c[0] = NUM_W'(fld[7]) - NUM_W'(fld[5]);
         n_c[1] = NUM_W'(fld[2]) - NUM_W'(fld[6]);
         n_c[2] = NUM_W'(fld[3]) - NUM_W'(fld[1]);
      end else if (fld[0] > fld[4] && fld[0] > fld[8]) begin
         br_c   = BR_X;
         rad_s  = one_c + ux_e - vy_e - wz_e;
         n_c[0] = NUM_W'(fld[3]) + NUM_W'(fld[1]);
         n_c[1] = NUM_W'(fld[2]) + NUM_W'(fld[6]);
         n_c[2] = NUM_W'(fld[7]) - NUM_W'(fld[5]);
      end else if (fld[4] > fld[8]) begin
         br_c   = BR_Y;
         rad_s  = one_c + vy_e - ux_e - wz_e;
         n_c[0] = NUM_W'(fld[3]) + NUM_W'(fld[1]);
         n_c[1] = NUM_W'(fld[7]) + NUM_W'(fld[5]);
         n_c[2] = NUM_W'(fld[2]) - NUM_W'(fld[6]);
      end else begin
         br_c   = BR_Z;
         rad_s  = one_c + wz_e - ux_e - vy_e;
         n_c[0] = NUM_W'(fld[2]) + NUM_W'(fld[6]);
         n_c[1] = NUM_W'(fld[7]) + NUM_W'(fld[5]);
         n_c[2] = NUM_W'(fld[3]) - NUM_W'(fld[1]);
      end
      // non-orthonormal input can drive the radicand negative
      rad_c    = (rad_s < 0) ? '0 : rad_s[RAD_W-1:0];
      fside_in = {br_c, n_c[2], n_c[1], n_c[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (en) begin
         front_valid_ff <= req_tvalid;
      end
      if (en) begin
         rad_ff   <= rad_c;
         fside_ff <= fside_in;
      end
   end

   // ---------------- square root chain ----------------
   logic                 sq_valid [0:QW];
   logic [VW-1:0]        sq_val   [0:QW];
   logic [QW+1:0]        sq_rem   [0:QW];
   logic [QW-1:0]        sq_root  [0:QW];
   logic [SQ_SIDE_W-1:0] sq_side  [0:QW];

   assign sq_valid[0] = front_valid_ff;
   assign sq_val[0]   = VW'(rad_ff) << FRAC_BITS;
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_side[0]  = fside_ff;

   for (genvar i = 0; i < QW; i++) begin : g_sqrt
      rmq_sqrt_cell #(
         .VW     (VW),
         .QW     (QW),
         .SIDE_W (SQ_SIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sq_valid[i]),
         .in_val    (sq_val[i]),
         .in_rem    (sq_rem[i]),
         .in_root   (sq_root[i]),
         .in_side   (sq_side[i]),
         .out_valid (sq_valid[i+1]),
         .out_val   (sq_val[i+1]),
         .out_rem   (sq_rem[i+1]),
         .out_root  (sq_root[i+1]),
         .out_side  (sq_side[i+1])
      );
   end

   // ---------------- divider setup ----------------
   logic [QW-1:0]          r_c;
   logic [QW:0]            r_inc;
   logic signed [NUM_W-1:0] sn [0:2];
   logic [NUM_W-1:0]       mag [0:2];
   logic [2:0][DW-1:0]     dvd_in, dvd_ff;
   logic [2:0]             sgn_c;
   logic [DV_SIDE_W-1:0]   pside_in, pside_ff;
   logic [SW-1:0]          s_ff;
   logic                   pr_valid_ff;

   always_comb begin
      r_c   = sq_root[QW];
      r_inc = {1'b0, r_c} + (QW+1)'(1);
      for (int k = 0; k < 3; k++) begin
         sn[k]     = sq_side[QW][k*NUM_W +: NUM_W];
         sgn_c[k]  = sn[k][NUM_W-1];
         mag[k]    = sgn_c[k] ? NUM_W'(-sn[k]) : NUM_W'(sn[k]);
         // rounding term s/2 = r
         dvd_in[k] = (DW'(mag[k]) << FRAC_BITS) + DW'(r_c);
      end
      pside_in = {sq_side[QW][SQ_SIDE_W-1 -: 2], sgn_c, (r_c == '0), r_inc[QW:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_valid_ff <= 1'b0;
      end else if (en) begin
         pr_valid_ff <= sq_valid[QW];
      end
      if (en) begin
         dvd_ff   <= dvd_in;
         s_ff     <= {r_c, 1'b0};
         pside_ff <= pside_in;
      end
   end

   // ---------------- divider chain ----------------
   logic                 dv_valid [0:DW];
   logic [SW-1:0]        dv_s     [0:DW];
   logic [2:0][DW-1:0]   dv_dvd   [0:DW];
   logic [2:0][SW-1:0]   dv_rem   [0:DW];
   logic [2:0][DW-1:0]   dv_quo   [0:DW];
   logic [DV_SIDE_W-1:0] dv_side  [0:DW];

   assign dv_valid[0] = pr_valid_ff;
   assign dv_s[0]     = s_ff;
   assign dv_dvd[0]   = dvd_ff;
   assign dv_rem[0]   = '0;
   assign dv_quo[0]   = '0;
   assign dv_side[0]  = pside_ff;

   for (genvar i = 0; i < DW; i++) begin : g_div
      rmq_div_cell #(
         .DW     (DW),
         .SW     (SW),
         .SIDE_W (DV_SIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dv_valid[i]),
         .in_s      (dv_s[i]),
         .in_dvd    (dv_dvd[i]),
         .in_rem    (dv_rem[i]),
         .in_quo    (dv_quo[i]),
         .in_side   (dv_side[i]),
         .out_valid (dv_valid[i+1]),
         .out_s     (dv_s[i+1]),
         .out_dvd   (dv_dvd[i+1]),
         .out_rem   (dv_rem[i+1]),
         .out_quo   (dv_quo[i+1]),
         .out_side  (dv_side[i+1])
      );
   end

   // ---------------- sign, saturate, route ----------------
   logic [FIELD_W-1:0]    lane [0:2];
   logic [FIELD_W-1:0]    qtr;
   logic [DW-1:0]         quo;
   logic [DW-1:0]         quo_neg;
   logic [QW-1:0]         qtr_raw;
   logic [QT_W-1:0]       qtr_x;
   branch_type            br_o;
   logic                  zero_o;
   logic [2:0]            sgn_o;
   logic [OUT_DATA_W-1:0] data_in, rsp_data_ff;
   logic                  rsp_valid_ff;

   always_comb begin
      qtr_raw = dv_side[DW][QW-1:0];
      zero_o  = dv_side[DW][QW];
      sgn_o   = dv_side[DW][QW+1 +: 3];
      br_o    = branch_type'(dv_side[DW][DV_SIDE_W-1 -: 2]);
      for (int k = 0; k < 3; k++) begin
         quo     = dv_quo[DW][k];
         quo_neg = -quo;
         if (sgn_o[k]) begin
            lane[k] = (quo > DW'(32768)) ? SAT_MIN : quo_neg[FIELD_W-1:0];
         end else begin
            lane[k] = (quo > DW'(32767)) ? SAT_MAX : quo[FIELD_W-1:0];
         end
      end
      qtr_x = QT_W'(qtr_raw);
      qtr   = (qtr_x > QT_W'(32767)) ? SAT_MAX : qtr_x[FIELD_W-1:0];
      unique case (br_o)
         BR_W:    data_in = {qtr, lane[2], lane[1], lane[0]};
         BR_X:    data_in = {lane[2], lane[1], lane[0], qtr};
         BR_Y:    data_in = {lane[2], lane[1], qtr, lane[0]};
         BR_Z:    data_in = {lane[2], qtr, lane[1], lane[0]};
         default: data_in = '0;
      endcase
      if (zero_o) begin
         data_in = '0;
      end
   end

   assign en = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid[DW];
      end
      if (en) begin
         rsp_data_ff <= data_in;
      end
   end

   assign req_tready = en;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> sv/rmq_sqrt_cell.sv
// One digit cell of the square root chain: resolves one root bit per beat.
module rmq_sqrt_cell #(
   parameter int VW     = 34,
   parameter int QW     = 17,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [VW-1:0]     in_val,
   input  logic [QW+1:0]     in_rem,
   input  logic [QW-1:0]     in_root,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [VW-1:0]     out_val,
   output logic [QW+1:0]     out_rem,
   output logic [QW-1:0]     out_root,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff;
   logic [VW-1:0]     val_ff, val_in;
   logic [QW+1:0]     rem_ff, rem_in, rem2, trial;
   logic [QW-1:0]     root_ff, root_in;
   logic [SIDE_W-1:0] side_ff;
   logic              ge;

   always_comb begin
      rem2    = {in_rem[QW-1:0], in_val[VW-1:VW-2]};
      trial   = {in_root, 2'b01};
      ge      = (rem2 >= trial);
      rem_in  = ge ? (rem2 - trial) : rem2;
      root_in = {in_root[QW-2:0], ge};
      val_in  = {in_val[VW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         val_ff  <= val_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_val   = val_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;

endmodule

>>> sv/rmq_div_cell.sv
// One restoring division cell: one quotient bit per beat for three lanes sharing a divisor.
module rmq_div_cell #(
   parameter int DW     = 32,
   parameter int SW     = 18,
   parameter int SIDE_W = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [SW-1:0]       in_s,
   input  logic [2:0][DW-1:0]  in_dvd,
   input  logic [2:0][SW-1:0]  in_rem,
   input  logic [2:0][DW-1:0]  in_quo,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [SW-1:0]       out_s,
   output logic [2:0][DW-1:0]  out_dvd,
   output logic [2:0][SW-1:0]  out_rem,
   output logic [2:0][DW-1:0]  out_quo,
   output logic [SIDE_W-1:0]   out_side
);

   logic               valid_ff;
   logic [SW-1:0]      s_ff;
   logic [2:0][DW-1:0] dvd_ff, dvd_in, quo_ff, quo_in;
   logic [2:0][SW-1:0] rem_ff, rem_in;
   logic [SIDE_W-1:0]  side_ff;
   logic [SW:0]        rem2 [0:2];
   logic [SW:0]        rem2_sub [0:2];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rem2[k]     = {in_rem[k], in_dvd[k][DW-1]};
         rem2_sub[k] = rem2[k] - {1'b0, in_s};
         if (rem2[k] >= {1'b0, in_s}) begin
            rem_in[k] = rem2_sub[k][SW-1:0];
            quo_in[k] = {in_quo[k][DW-2:0], 1'b1};
         end else begin
            rem_in[k] = rem2[k][SW-1:0];
            quo_in[k] = {in_quo[k][DW-2:0], 1'b0};
         end
         dvd_in[k] = {in_dvd[k][DW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         s_ff    <= in_s;
         dvd_ff  <= dvd_in;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_s     = s_ff;
   assign out_dvd   = dvd_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_side  = side_ff;

endmodule
